// ----- rtl/hse_pkg.sv -----
// Package for the Huffman stream encoder: request kinds, widths and the
// hand-off structure between the encoder core and its byte packer.
// No dependencies.
`default_nettype none

package hse_pkg;

   localparam int MAX_CODE_LEN  = 64;
   localparam int ALPHABET_SIZE = 256;
   localparam int BYTE_BITS     = 8;

   localparam int SYM_W    = $clog2(ALPHABET_SIZE);
   localparam int LEN_W    = 7;
   localparam int CNT_W    = 3;
   localparam int PEND_W   = BYTE_BITS - 1;
   localparam int WIN_W    = MAX_CODE_LEN + BYTE_BITS;
   localparam int NBYTE_W  = 4;
   localparam int REQ_DATA_W = 80;
   localparam int ENTRY_W  = LEN_W + MAX_CODE_LEN;

   typedef enum logic [1:0] {
      KIND_LOAD   = 2'd0,
      KIND_ENCODE = 2'd1,
      KIND_FLUSH  = 2'd2
   } hse_kind_type;

   // Left-aligned bit window plus the number of whole bytes in it.
   typedef struct packed {
      logic [WIN_W-1:0]   window;
      logic [NBYTE_W-1:0] count;
   } hse_pack_type;

endpackage

`default_nettype wire

// ----- rtl/hse_byte_packer.sv -----
// Byte packer: holds a left-aligned window and sends its whole bytes on
// rsp_, one per cycle while rsp_tready is high. Depends on hse_pkg.
`default_nettype none

module hse_byte_packer (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire hse_pkg::hse_pack_type pack,
   output logic                      free,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [7:0]                rsp_tdata,   // [7:0] out_byte
   output logic                      rsp_tlast    // last
);
   import hse_pkg::*;

   logic [WIN_W-1:0]   window_ff, window_in;
   logic [NBYTE_W-1:0] count_ff, count_in;
   logic               take;

   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata  = window_ff[WIN_W-1 -: BYTE_BITS];
   assign rsp_tlast  = (count_ff == NBYTE_W'(1));
   assign take       = rsp_tvalid && rsp_tready;
   assign free       = (count_ff == '0) || (rsp_tlast && rsp_tready);

   always_comb begin
      window_in = window_ff;
      count_in  = count_ff;
      if (load) begin
         window_in = pack.window;
         count_in  = pack.count;
      end else if (take) begin
         window_in = window_ff << BYTE_BITS;
         count_in  = count_ff - NBYTE_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      window_ff <= window_in;
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= NBYTE_W'(MAX_CODE_LEN / BYTE_BITS + 1))
      else $error("byte count out of range");

   a_drain_ends: assert property (@(posedge clock) disable iff (reset)
      (take && rsp_tlast && !load) |=> !rsp_tvalid)
      else $error("response valid after last byte");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready && !load) |=> $stable(window_ff) && $stable(count_ff))
      else $error("window changed during stall");

endmodule

`default_nettype wire

// ----- rtl/huffman_stream_encoder_core.sv -----
// Top level of the Huffman stream encoder: code table memory, bit
// accumulator and response packing. Depends on hse_pkg and hse_byte_packer.
`default_nettype none

// Usage:
// Requests arrive on the req_ stream. req_tuser carries the kind (load,
// encode, flush); req_tdata carries symbol, code length and code bits.
// A load writes the symbol's entry of a 256 x 71 bit code table memory; an
// encode reads it, appends the code (first bit most significant) to the
// pending bits and emits every full byte on the rsp_ stream; a flush pads
// the pending bits with zeros and emits them as one byte. rsp_tlast marks
// the final byte a request produced. Requests that produce no byte (loads,
// zero-length codes, flushes with nothing pending, unknown kinds) emit
// nothing.
// A request's table entry is registered when the request is accepted; the
// append stage then loads its bytes into the packer, which drives rsp_.
// Throughput: one request per cycle while each request produces at most
// one byte and the receiver is ready; a request that produces n bytes, up
// to eight for a 64-bit code, holds the response port until all are sent.
// Reset clears the pending bits and all valid flags; the table itself is
// not cleared and an entry must be loaded before it is encoded.
// When the receiver stalls, bytes hold on rsp_ and the pipeline keeps one
// request in the append stage and one in the packer before req_tready drops.
module huffman_stream_encoder_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   // [7:0] symbol, [14:8] code_length, [78:15] code_bits, [79] zero
   input  wire logic [hse_pkg::REQ_DATA_W-1:0] req_tdata,
   input  wire logic [1:0]                    req_tuser,  // [1:0] kind
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [7:0]                         rsp_tdata,  // [7:0] out_byte
   output logic                               rsp_tlast   // last
);
   import hse_pkg::*;

   // Request fields.
   logic [SYM_W-1:0]        req_symbol;
   logic [LEN_W-1:0]        req_length;
   logic [MAX_CODE_LEN-1:0] req_bits;
   logic [LEN_W-1:0]        req_length_clamped;
   logic                    req_accept;

   assign req_symbol = req_tdata[SYM_W-1:0];
   assign req_length = req_tdata[SYM_W +: LEN_W];
   assign req_bits   = req_tdata[SYM_W+LEN_W +: MAX_CODE_LEN];
   assign req_length_clamped = (req_length > LEN_W'(MAX_CODE_LEN)) ?
                               LEN_W'(MAX_CODE_LEN) : req_length;
   assign req_accept = req_tvalid && req_tready;

   // Code table: each entry holds {length, bits}. Read data is registered
   // and only changes when a new request is accepted, so it stays put while
   // the append stage is stalled. A load and a later encode of the same
   // symbol never collide: the write lands at the load's accept edge,
   // before the encode's read.
   logic [ENTRY_W-1:0] table_mem [ALPHABET_SIZE];
   logic [ENTRY_W-1:0] rd_entry_ff;

   always_ff @(posedge clock) begin
      if (req_accept && (hse_kind_type'(req_tuser) == KIND_LOAD)) begin
         table_mem[req_symbol] <= {req_length_clamped, req_bits};
      end
      if (req_accept) begin
         rd_entry_ff <= table_mem[req_symbol];
      end
   end

   // Append stage.
   logic         stage_valid_ff, stage_valid_in;
   hse_kind_type stage_kind_ff;
   logic         stage_move;
   logic         packer_free;

   logic [CNT_W-1:0]  pend_cnt_ff, pend_cnt_in;
   logic [PEND_W-1:0] pend_bits_ff, pend_bits_in;

   logic [LEN_W-1:0]        code_len;
   logic [MAX_CODE_LEN-1:0] code_bits;
   logic [MAX_CODE_LEN:0]   code_mask;
   logic [WIN_W-2:0]        joined;
   logic [LEN_W-1:0]        total;
   logic [WIN_W-1:0]        aligned;
   logic [BYTE_BITS-1:0]    rem_mask;
   logic                    pack_load;
   hse_pack_type            pack;

   assign code_len   = rd_entry_ff[ENTRY_W-1 -: LEN_W];
   assign code_bits  = rd_entry_ff[MAX_CODE_LEN-1:0];
   assign stage_move = stage_valid_ff && packer_free;
   assign req_tready = !stage_valid_ff || stage_move;

   always_comb begin
      // Pending bits followed by the code, right-aligned, and then moved so
      // the earliest bit sits at the top of the window.
      code_mask = ((MAX_CODE_LEN+1)'(1) << code_len) - (MAX_CODE_LEN+1)'(1);
      joined    = ((WIN_W-1)'(pend_bits_ff) << code_len) |
                  (WIN_W-1)'(code_bits & code_mask[MAX_CODE_LEN-1:0]);
      total     = LEN_W'(pend_cnt_ff) + code_len;
      aligned   = {1'b0, joined} << (LEN_W'(WIN_W) - total);
      rem_mask  = (BYTE_BITS'(1) << total[CNT_W-1:0]) - BYTE_BITS'(1);
   end

   always_comb begin
      pack.window  = aligned;
      pack.count   = '0;
      pend_cnt_in  = pend_cnt_ff;
      pend_bits_in = pend_bits_ff;
      unique case (stage_kind_ff)
         KIND_ENCODE: begin
            pack.count   = total[LEN_W-1:CNT_W];
            pend_cnt_in  = total[CNT_W-1:0];
            pend_bits_in = joined[PEND_W-1:0] & rem_mask[PEND_W-1:0];
         end
         KIND_FLUSH: begin
            // With no code read in, the window is just the pending bits
            // padded with zeros below them.
            pack.window  = {1'b0, (WIN_W-1)'(pend_bits_ff)} <<
                           (LEN_W'(WIN_W) - LEN_W'(pend_cnt_ff));
            pack.count   = (pend_cnt_ff != '0) ? NBYTE_W'(1) : NBYTE_W'(0);
            pend_cnt_in  = '0;
            pend_bits_in = '0;
         end
         default: begin
         end
      endcase
      if (!stage_move) begin
         pend_cnt_in  = pend_cnt_ff;
         pend_bits_in = pend_bits_ff;
      end
   end

   assign pack_load = stage_move;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (req_accept) begin
         stage_valid_in = 1'b1;
      end else if (stage_move) begin
         stage_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         stage_kind_ff <= hse_kind_type'(req_tuser);
      end
      if (reset) begin
         stage_valid_ff <= 1'b0;
         pend_cnt_ff    <= '0;
         pend_bits_ff   <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         pend_cnt_ff    <= pend_cnt_in;
         pend_bits_ff   <= pend_bits_in;
      end
   end

   hse_byte_packer u_packer (
      .clock      (clock),
      .reset      (reset),
      .load       (pack_load),
      .pack       (pack),
      .free       (packer_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff && !stage_move) |=> stage_valid_ff && $stable(stage_kind_ff))
      else $error("append stage lost a stalled request");

   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      (stage_move && stage_kind_ff == KIND_FLUSH) |=> (pend_cnt_ff == '0))
      else $error("flush left pending bits");

   a_pending_masked: assert property (@(posedge clock) disable iff (reset)
      (pend_bits_ff >> pend_cnt_ff) == '0)
      else $error("pending bits above pending count");

endmodule

`default_nettype wire
